### sv/cpss_pkg.sv
// Package for the closest probe search: words, codes, states and defaults.
`default_nettype none

package cpss_pkg;

  localparam int CPSS_MAX_PROBES = 1024;
  localparam int CPSS_MAX_POINTS = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_POINT  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  localparam logic signed [10:0] IDX_NONE = -11'sd1;
  localparam logic signed [10:0] IDX_ZERO = 11'sd0;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] probe_x;
    logic signed [15:0] probe_y;
    logic signed [15:0] probe_z;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               has_side;
    logic               has_polygon;
  } in_word_t;

  typedef struct packed {
    logic signed [10:0] probe_index;
    logic               from_front;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } probe_t;

endpackage

`default_nettype wire

### sv/cpss_probe_mem.sv
// Probe table: simple dual-port RAM with registered read data.
`default_nettype none

module cpss_probe_mem
  import cpss_pkg::*;
#(
  parameter int MAX_PROBES = CPSS_MAX_PROBES,
  localparam int AW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire probe_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output probe_t             rdata_o
);

  probe_t mem [MAX_PROBES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/cpss_dist_pipe.sv
// Distance pipeline: scaled delta, squares and normal products, sums.
`default_nettype none

module cpss_dist_pipe
  import cpss_pkg::*;
#(
  parameter int MAX_PROBES = CPSS_MAX_PROBES,
  parameter int MAX_POINTS = CPSS_MAX_POINTS,
  localparam int AW  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1,
  localparam int PCW = $clog2(MAX_POINTS + 1),
  localparam int DW  = 26 + PCW,
  localparam int SQW = 2 * DW + 1,
  localparam int DTW = DW + 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 issue_i,
  input  wire logic [AW-1:0]        issue_idx_i,
  input  wire probe_t               rdata_i,
  input  wire logic [PCW-1:0]       n_i,
  input  wire logic [2:0][DW-1:0]   cen_i,
  input  wire logic [2:0][15:0]     nrm_i,
  output logic                      smp_valid_o,
  output logic [AW-1:0]             smp_idx_o,
  output logic [SQW-1:0]            smp_d2_o,
  output logic                      smp_front_o,
  output logic                      busy_o
);

  logic              v0_q, v1_q, v2_q, v3_q;
  logic [AW-1:0]     i0_q, i1_q, i2_q, i3_q;

  logic signed [15:0]      lane [3];
  logic signed [DW-1:0]    nsig;
  logic signed [DW-1:0]    d_d [3];
  logic signed [DW-1:0]    d1_q [3];
  logic signed [2*DW-1:0]  sq_d [3];
  logic [2*DW-2:0]         sq_q [3];
  logic signed [DTW-1:0]   dp_d [3];
  logic signed [DTW-1:0]   dp_q [3];
  logic [SQW-1:0]          d2_d;
  logic signed [DTW-1:0]   dot_d;
  logic [SQW-1:0]          d2_q;
  logic                    front_q;

  assign lane[0] = rdata_i.x;
  assign lane[1] = rdata_i.y;
  assign lane[2] = rdata_i.z;
  assign nsig    = DW'($signed({1'b0, n_i}));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k] = ((DW'(lane[k]) * nsig) <<< 8) - $signed(cen_i[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = (2*DW)'(d1_q[k]) * (2*DW)'(d1_q[k]);
      dp_d[k] = DTW'(d1_q[k]) * DTW'($signed(nrm_i[k]));
    end
  end

  always_comb begin
    d2_d  = SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
    dot_d = dp_q[0] + dp_q[1] + dp_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= issue_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i0_q <= issue_idx_i;
    i1_q <= i0_q;
    i2_q <= i1_q;
    i3_q <= i2_q;
    for (int k = 0; k < 3; k++) begin
      d1_q[k] <= d_d[k];
      sq_q[k] <= sq_d[k][2*DW-2:0];
      dp_q[k] <= dp_d[k];
    end
    d2_q    <= d2_d;
    front_q <= !dot_d[DTW-1];
  end

  assign smp_valid_o = v3_q;
  assign smp_idx_o   = i3_q;
  assign smp_d2_o    = d2_q;
  assign smp_front_o = front_q;
  assign busy_o      = v0_q | v1_q | v2_q | v3_q;

endmodule

`default_nettype wire

### sv/cpss_best_sel.sv
// Running minimum over the samples: nearest in front and nearest overall.
`default_nettype none

module cpss_best_sel
  import cpss_pkg::*;
#(
  parameter int MAX_PROBES = CPSS_MAX_PROBES,
  parameter int MAX_POINTS = CPSS_MAX_POINTS,
  localparam int AW  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1,
  localparam int PCW = $clog2(MAX_POINTS + 1),
  localparam int SQW = 2 * (26 + PCW) + 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire logic            smp_valid_i,
  input  wire logic [AW-1:0]   smp_idx_i,
  input  wire logic [SQW-1:0]  smp_d2_i,
  input  wire logic            smp_front_i,
  output logic                 has_front_o,
  output logic [AW-1:0]        idx_front_o,
  output logic [AW-1:0]        idx_all_o
);

  logic            has_front_q, has_all_q;
  logic [SQW-1:0]  best_front_q, best_all_q;
  logic [AW-1:0]   idx_front_q, idx_all_q;
  logic            take_front, take_all;

  // strict compare keeps the lowest index on ties
  assign take_front = smp_valid_i && smp_front_i && (!has_front_q || smp_d2_i < best_front_q);
  assign take_all   = smp_valid_i && (!has_all_q || smp_d2_i < best_all_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_front_q <= 1'b0;
      has_all_q   <= 1'b0;
    end else if (clear_i) begin
      has_front_q <= 1'b0;
      has_all_q   <= 1'b0;
    end else begin
      if (take_front) has_front_q <= 1'b1;
      if (take_all)   has_all_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_front) begin
      best_front_q <= smp_d2_i;
      idx_front_q  <= smp_idx_i;
    end
    if (take_all) begin
      best_all_q <= smp_d2_i;
      idx_all_q  <= smp_idx_i;
    end
  end

  assign has_front_o = has_front_q;
  assign idx_front_o = idx_front_q;
  assign idx_all_o   = idx_all_q;

endmodule

`default_nettype wire

### sv/closest_probe_search_core.sv
// Closest probe search: top level with command decode, sums, scan control and output word.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+-----------
//   in      | input     | in_valid_i / in_stall_o   | in_word_t
//   out     | output    | out_valid_o / out_stall_i | out_word_t
//
// Clear, append and point words do not stall the input.
// In a scanning query the table RAM is read one entry per cycle, followed by
// the drain of the distance pipeline.
// Queries resolved without a scan go straight to the output state.
// Reset clears counts, sums and control; table contents stay undefined.
// Input stalls while a query is in progress or its result waits for the output register.
`default_nettype none

module closest_probe_search_core
  import cpss_pkg::*;
#(
  parameter int MAX_PROBES = CPSS_MAX_PROBES,
  parameter int MAX_POINTS = CPSS_MAX_POINTS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int AW  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int CW  = $clog2(MAX_PROBES + 1);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int SW  = 24 + PCW;
  localparam int DW  = 26 + PCW;
  localparam int SQW = 2 * DW + 1;

  state_e state_q, state_d;

  logic [CW-1:0]         probe_count_q;
  logic [PCW-1:0]        point_count_q;
  logic signed [SW-1:0]  sum_q [3];
  logic [CW-1:0]         icnt_q;
  logic [PCW-1:0]        n_q;
  logic signed [DW-1:0]  cen_q [3];
  logic signed [15:0]    nrm_q [3];
  logic [2:0][DW-1:0]    cen_pk;
  logic [2:0][15:0]      nrm_pk;
  out_word_t             res_q;
  out_word_t             out_q;
  logic                  out_valid_q;

  logic signed [23:0]    pt [3];
  logic signed [15:0]    nin [3];
  logic signed [DW-1:0]  nsig;

  logic in_accept, is_query, scan_ok, last_issue;
  logic rd_en, load_best, out_load, start_scan;

  probe_t           wdata, rdata;
  logic             smp_valid, smp_front, busy;
  logic [AW-1:0]    smp_idx;
  logic [SQW-1:0]   smp_d2;
  logic             has_front;
  logic [AW-1:0]    idx_front, idx_all, idx_pick;
  logic [AW+10:0]   idx_ext;

  assign pt[0]  = in_word_i.point_x;
  assign pt[1]  = in_word_i.point_y;
  assign pt[2]  = in_word_i.point_z;
  assign nin[0] = in_word_i.normal_x;
  assign nin[1] = in_word_i.normal_y;
  assign nin[2] = in_word_i.normal_z;
  assign nsig   = DW'($signed({1'b0, point_count_q}));

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign is_query   = (in_word_i.cmd == CMD_QUERY);
  assign scan_ok    = in_word_i.has_side && in_word_i.has_polygon &&
                      (point_count_q != '0) && (probe_count_q != '0);
  assign last_issue = (icnt_q + CW'(1)) == probe_count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && is_query) begin
          state_d = scan_ok ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    rd_en      = (state_q == ST_SCAN);
    load_best  = (state_q == ST_DRAIN) && !busy;
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
    start_scan = in_accept && is_query && scan_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_count_q <= '0;
      point_count_q <= '0;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
    end else if (in_accept) begin
      unique case (in_word_i.cmd)
        CMD_CLEAR: probe_count_q <= '0;
        CMD_APPEND: begin
          if (probe_count_q < CW'(MAX_PROBES)) probe_count_q <= probe_count_q + CW'(1);
        end
        CMD_POINT: begin
          if (point_count_q < PCW'(MAX_POINTS)) begin
            point_count_q <= point_count_q + PCW'(1);
            for (int k = 0; k < 3; k++) sum_q[k] <= sum_q[k] + SW'(pt[k]);
          end
        end
        CMD_QUERY: begin
          point_count_q <= '0;
          for (int k = 0; k < 3; k++) sum_q[k] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icnt_q <= '0;
    end else if (start_scan) begin
      icnt_q <= '0;
    end else if (rd_en) begin
      icnt_q <= icnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_query) begin
      n_q <= point_count_q;
      for (int k = 0; k < 3; k++) begin
        cen_q[k] <= DW'(sum_q[k]) + DW'(pt[k]) * nsig;
        nrm_q[k] <= nin[k];
      end
      if (!in_word_i.has_side) begin
        res_q <= '{probe_index: IDX_NONE, from_front: 1'b0};
      end else if (!in_word_i.has_polygon || point_count_q == '0) begin
        res_q <= '{probe_index: IDX_ZERO, from_front: 1'b0};
      end else begin
        res_q <= '{probe_index: IDX_NONE, from_front: 1'b0};
      end
    end else if (load_best) begin
      res_q <= '{probe_index: $signed(idx_ext[10:0]), from_front: has_front};
    end
  end

  assign idx_pick = has_front ? idx_front : idx_all;
  assign idx_ext  = {11'b0, idx_pick};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign wdata = '{x: in_word_i.probe_x, y: in_word_i.probe_y, z: in_word_i.probe_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cen_pk[k] = cen_q[k];
      nrm_pk[k] = nrm_q[k];
    end
  end

  cpss_probe_mem #(
    .MAX_PROBES(MAX_PROBES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_accept && (in_word_i.cmd == CMD_APPEND) &&
              (probe_count_q < CW'(MAX_PROBES))),
    .waddr_i (probe_count_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (icnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  cpss_dist_pipe #(
    .MAX_PROBES(MAX_PROBES),
    .MAX_POINTS(MAX_POINTS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (rd_en),
    .issue_idx_i (icnt_q[AW-1:0]),
    .rdata_i     (rdata),
    .n_i         (n_q),
    .cen_i       (cen_pk),
    .nrm_i       (nrm_pk),
    .smp_valid_o (smp_valid),
    .smp_idx_o   (smp_idx),
    .smp_d2_o    (smp_d2),
    .smp_front_o (smp_front),
    .busy_o      (busy)
  );

  cpss_best_sel #(
    .MAX_PROBES(MAX_PROBES),
    .MAX_POINTS(MAX_POINTS)
  ) u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (start_scan),
    .smp_valid_i (smp_valid),
    .smp_idx_i   (smp_idx),
    .smp_d2_i    (smp_d2),
    .smp_front_i (smp_front),
    .has_front_o (has_front),
    .idx_front_o (idx_front),
    .idx_all_o   (idx_all)
  );

endmodule

`default_nettype wire
